// File: rtl/qte_pkg.sv
// shared types and constants for the quaternion to euler angle converter
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

	// widths of the datapath
	localparam int SUM_W  = 34;   // 2(ab+cd) and 1-2(..) terms at 2^-28 scale
	localparam int CRD_W  = 38;   // cordic x and y
	localparam int ACC_W  = 27;   // cordic angle accumulator, 1/65536 degree
	localparam int MAG_W  = 28;   // |s| below one
	localparam int REM_W  = 57;   // 2^56 - s^2
	localparam int ROOT_W = 58;   // square root working register
	localparam int SQRT_CELLS = 29;
	localparam int MAX_STAGES = 24;

	localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(64'sd268435456);
	localparam logic signed [ACC_W-1:0] DEG180  = ACC_W'(180 * 65536);
	localparam int LIM_FULL = 23040;
	localparam int LIM_HALF = 11520;

	// atan(2^-i) in 1/65536 degree, rounded
	localparam logic [21:0] ATAN_TAB [MAX_STAGES] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

	// one cordic cell's working set
	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [ACC_W-1:0] acc;
		logic                    zero;
	} cordic_t;

	// one square root cell's working set
	typedef struct packed {
		logic [REM_W-1:0]  v;
		logic [ROOT_W-1:0] r;
	} sqrt_t;

	// terms held back while the pitch root is worked out
	typedef struct packed {
		logic signed [SUM_W-1:0] sr;
		logic signed [SUM_W-1:0] cr;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] cy;
		logic signed [SUM_W-1:0] sp;
		logic                    clamp;
		logic                    neg;
	} terms_t;

	// pitch saturation info
	typedef struct packed {
		logic clamp;
		logic neg;
	} sat_t;

endpackage
`default_nettype wire

// File: rtl/qte_sqrt_cell.sv
// one bit step of the pipelined floor square root
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt_cell
	import qte_pkg::*;
#(
	parameter int K = 0
) (
	input  wire        clk,
	input  wire        en,
	input  sqrt_t      din,
	output sqrt_t      dout
);

	localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * K);

	logic [ROOT_W-1:0] trial;
	sqrt_t             nxt;

	// trial subtract of res + bit
	always_comb begin
		trial = din.r + BIT;
		if ({1'b0, din.v} >= trial) begin
			nxt.v = din.v - trial[REM_W-1:0];
			nxt.r = (din.r >> 1) + BIT;
		end else begin
			nxt.v = din.v;
			nxt.r = din.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: rtl/qte_cordic_cell.sv
// one vectoring step of the cordic row
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell
	import qte_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  wire     clk,
	input  wire     en,
	input  cordic_t din,
	output cordic_t dout
);

	localparam logic signed [ACC_W-1:0] T = ACC_W'(ATAN_TAB[STAGE]);

	cordic_t nxt;

	// rotate towards the x axis
	always_comb begin
		nxt.zero = din.zero;
		if (din.y > 0) begin
			nxt.x   = din.x + (din.y >>> STAGE);
			nxt.y   = din.y - (din.x >>> STAGE);
			nxt.acc = din.acc + T;
		end else begin
			nxt.x   = din.x - (din.y >>> STAGE);
			nxt.y   = din.y + (din.x >>> STAGE);
			nxt.acc = din.acc - T;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: rtl/qte_cordic.sv
// cordic atan2: quadrant fold, row of cells, rounding and clamp
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic
	import qte_pkg::*;
#(
	parameter int STAGES = 16,
	parameter int LIM    = 23040
) (
	input  wire                     clk,
	input  wire                     en,
	input  wire signed [CRD_W-1:0]  y_in,
	input  wire signed [CRD_W-1:0]  x_in,
	output logic signed [15:0]      angle_q
);

	localparam logic signed [ACC_W:0] LIM_P = (ACC_W + 1)'(LIM);
	localparam logic signed [ACC_W:0] LIM_N = -LIM_P;

	cordic_t row [STAGES+1];
	cordic_t pre;

	// fold the left half plane onto the right
	always_comb begin
		pre.zero = (x_in == '0) && (y_in == '0);
		if (x_in < 0) begin
			pre.x   = -x_in;
			pre.y   = -y_in;
			pre.acc = (y_in >= 0) ? DEG180 : -DEG180;
		end else begin
			pre.x   = x_in;
			pre.y   = y_in;
			pre.acc = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row[0] <= pre;
		end
	end

	// row of vectoring cells
	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		qte_cordic_cell #(.STAGE(i)) u_cell (
			.clk  (clk),
			.en   (en),
			.din  (row[i]),
			.dout (row[i+1])
		);
	end

	logic signed [ACC_W:0] rnd;
	logic signed [ACC_W:0] lim;

	// round to 1/128 degree and clamp
	always_comb begin
		rnd = ($signed({row[STAGES].acc[ACC_W-1], row[STAGES].acc}) + (ACC_W + 1)'(256)) >>> 9;
		if (rnd > LIM_P) begin
			lim = LIM_P;
		end else if (rnd < LIM_N) begin
			lim = LIM_N;
		end else begin
			lim = rnd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= row[STAGES].zero ? 16'sd0 : lim[15:0];
		end
	end

endmodule
`default_nettype wire

// File: rtl/quaternion_to_euler.sv
// quaternion to roll, pitch and yaw, fully pipelined
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle; products, a 29 cell square root row and
//   three cordic rows of CORDIC_STAGES cells each advance together
// the whole pipeline holds while a result waits on m_tready
// reset clears the valid bits only, no clearing pass
module quaternion_to_euler
	import qte_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
	output logic        m_tuser    // pitch_clamped
);

	localparam int DLY1 = SQRT_CELLS + 2;
	localparam int DLY2 = CORDIC_STAGES + 2;
	localparam int LAT  = CORDIC_STAGES + 36;

	logic en;
	logic [LAT-1:0] vld_q;

	assign m_tvalid = vld_q[LAT-1];
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// products
	logic signed [15:0] w, x, y, z;
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;

	assign w = s_tdata[15:0];
	assign x = s_tdata[31:16];
	assign y = s_tdata[47:32];
	assign z = s_tdata[63:48];

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= w * x;
			yz_s1 <= y * z;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			wz_s1 <= w * z;
			xy_s1 <= x * y;
			zz_s1 <= z * z;
			wy_s1 <= w * y;
			zx_s1 <= z * x;
		end
	end

	// sine and cosine terms
	terms_t t;
	terms_t t_s2;
	logic [MAG_W-1:0] mag_s2;
	logic signed [SUM_W-1:0] sp_abs;

	always_comb begin
		t.sr = ($signed(SUM_W'(wx_s1)) + $signed(SUM_W'(yz_s1))) <<< 1;
		t.cr = ONE_Q28 - (($signed(SUM_W'(xx_s1)) + $signed(SUM_W'(yy_s1))) <<< 1);
		t.sy = ($signed(SUM_W'(wz_s1)) + $signed(SUM_W'(xy_s1))) <<< 1;
		t.cy = ONE_Q28 - (($signed(SUM_W'(yy_s1)) + $signed(SUM_W'(zz_s1))) <<< 1);
		t.sp = ($signed(SUM_W'(wy_s1)) - $signed(SUM_W'(zx_s1))) <<< 1;
		t.clamp = (t.sp >= ONE_Q28) || (t.sp <= -ONE_Q28);
		t.neg   = t.sp[SUM_W-1];
		sp_abs  = t.neg ? -t.sp : t.sp;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2   <= t;
			mag_s2 <= sp_abs[MAG_W-1:0];
		end
	end

	// 1 - s^2 at 2^-56 scale
	logic [2*MAG_W-1:0] sq_s3;
	logic [REM_W-1:0]   rem_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3  <= mag_s2 * mag_s2;
			rem_s4 <= (REM_W'(1) << 56) - REM_W'(sq_s3);
		end
	end

	// square root row
	sqrt_t sq_row [SQRT_CELLS+1];

	assign sq_row[0].v = rem_s4;
	assign sq_row[0].r = '0;

	for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
		qte_sqrt_cell #(.K(SQRT_CELLS - 1 - j)) u_sqrt (
			.clk  (clk),
			.en   (en),
			.din  (sq_row[j]),
			.dout (sq_row[j+1])
		);
	end

	// hold the other terms alongside the root
	terms_t dly1_q [DLY1];

	always_ff @(posedge clk) begin
		if (en) begin
			dly1_q[0] <= t_s2;
			for (int i = 1; i < DLY1; i++) begin
				dly1_q[i] <= dly1_q[i-1];
			end
		end
	end

	// three angle rows
	logic signed [15:0] roll_c, pitch_c, yaw_c;
	terms_t tl;

	assign tl = dly1_q[DLY1-1];

	qte_cordic #(.STAGES(CORDIC_STAGES), .LIM(LIM_FULL)) u_roll (
		.clk     (clk),
		.en      (en),
		.y_in    (CRD_W'(tl.sr)),
		.x_in    (CRD_W'(tl.cr)),
		.angle_q (roll_c)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES), .LIM(LIM_FULL)) u_yaw (
		.clk     (clk),
		.en      (en),
		.y_in    (CRD_W'(tl.sy)),
		.x_in    (CRD_W'(tl.cy)),
		.angle_q (yaw_c)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES), .LIM(LIM_HALF)) u_pitch (
		.clk     (clk),
		.en      (en),
		.y_in    (CRD_W'(tl.sp)),
		.x_in    ($signed({{(CRD_W - 29){1'b0}}, sq_row[SQRT_CELLS].r[28:0]})),
		.angle_q (pitch_c)
	);

	// saturation info follows the cordic rows
	sat_t dly2_q [DLY2];

	always_ff @(posedge clk) begin
		if (en) begin
			dly2_q[0] <= '{clamp: tl.clamp, neg: tl.neg};
			for (int i = 1; i < DLY2; i++) begin
				dly2_q[i] <= dly2_q[i-1];
			end
		end
	end

	// output register
	logic signed [15:0] roll_q, yaw_q;
	logic signed [14:0] pitch_q;
	logic               clamp_q;
	sat_t               sl;

	assign sl = dly2_q[DLY2-1];

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= roll_c;
			yaw_q   <= yaw_c;
			clamp_q <= sl.clamp;
			if (sl.clamp) begin
				pitch_q <= sl.neg ? -15'(LIM_HALF) : 15'(LIM_HALF);
			end else begin
				pitch_q <= pitch_c[14:0];
			end
		end
	end

	assign m_tdata = {1'b0, yaw_q, pitch_q, roll_q};
	assign m_tuser = clamp_q;

endmodule
`default_nettype wire
